@@ rtl/tcfp_pkg.sv @@
package tcfp_pkg;

	localparam int MAX_FRAMES = 256;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int RAM_W      = 16 + 11 + 64;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_REFUSED = 2'd2;

	localparam logic [2:0] CFG_FRAME_COUNT = 3'd0;
	localparam logic [2:0] CFG_LOOP_ENABLE = 3'd1;
	localparam logic [2:0] CFG_LOOP_FROM   = 3'd2;
	localparam logic [2:0] CFG_NMT_ENABLE  = 3'd3;
	localparam logic [2:0] CFG_NODE_ID     = 3'd4;
	localparam logic [2:0] CFG_SETTLE_MS   = 3'd5;
	localparam logic [2:0] CFG_TX_CAP      = 3'd6;
	localparam logic [2:0] CFG_WINDOW_MS   = 3'd7;

	localparam logic [15:0] OFFSET_MAX    = 16'd65000;
	localparam logic [6:0]  NODE_ID_RST   = 7'd21;
	localparam logic [15:0] SETTLE_RST    = 16'd900;
	localparam logic [5:0]  TX_CAP_RST    = 6'd24;
	localparam logic [15:0] WINDOW_RST    = 16'd1000;
	localparam logic [5:0]  TICK_SEND_MAX = 6'd63;
	localparam logic [7:0]  NMT_START     = 8'h01;
	localparam logic [10:0] NMT_ID        = 11'h000;
	localparam logic [3:0]  LEN_TAPE      = 4'd8;
	localparam logic [3:0]  LEN_NMT       = 4'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  slot;
		logic [15:0] offset_ms;
		logic [10:0] frame_id;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] can_id;
		logic [63:0] can_data;
		logic [3:0]  can_len;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		RD_IDX,
		RD_LAST,
		RD_ZERO,
		RD_SCAN_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		PR_NONE,
		PR_FRAME,
		PR_NMT,
		PR_REFUSED,
		PR_DONE
	} prod_t;

	typedef struct packed {
		logic    load;
		logic    start;
		logic    stop;
		logic    tick;
		logic    advance;
		logic    lp_set;
		logic    scan_inc;
		logic    loop_hit;
		logic    finish;
		logic    flush;
		rd_sel_t rd_sel;
		prod_t   prod;
	} cmd_t;

	typedef struct packed {
		logic playing;
		logic settling;
		logic settle_gt1;
		logic table_empty;
		logic idx_ge_cnt;
		logic frame_late;
		logic cap_hit;
		logic scan_lt;
		logic scan_end;
		logic pend_valid;
		logic out_free;
		logic nmt_en;
		logic loop_en;
	} stat_t;

endpackage

@@ rtl/timed_can_frame_player.sv @@
// Channel    Direction  Handshake                 Payload
// request    in         req_valid / req_stall     req (op, slot, offset_ms, frame_id, payload)
// response   out        rsp_valid / rsp_stall     rsp (kind, can_id, can_data, can_len, last)
// config     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Load, stop and a tick while not playing or not ending settling complete in idle; a start with
// a result goes on to a flush. A playing tick sends due frames in turn until it meets a frame
// not yet due or the send cap, then flushes any pending result; a finish sends a done
// result. A loop search scans the table from index zero; the table has one read port.
// Reset clears all control state and loads register defaults; the table is not cleared.
// A stalled response holds the block once its one-deep pending result is full.
module timed_can_frame_player
	import tcfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;
	logic  busy;

	assign req_stall = busy;
	assign cfg_ready = 1'b1;

	tcfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.stat      (stat),
		.busy      (busy),
		.cmd       (cmd)
	);

	tcfp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

@@ rtl/tcfp_ram.sv @@
module tcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/tcfp_ctrl.sv @@
module tcfp_ctrl
	import tcfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_op,
	input  stat_t      stat,
	output logic       busy,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_FRAME,
		S_LP,
		S_SCAN,
		S_FINISH,
		S_FLUSH
	} state_t;

	state_t state_q, state_d;
	logic   can_prod;

	assign busy     = (state_q != S_IDLE);
	assign can_prod = !stat.pend_valid || stat.out_free;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel = RD_IDX;
		cmd.prod   = PR_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_op)
						OP_LOAD: cmd.load = 1'b1;
						OP_START: begin
							if (stat.table_empty) begin
								cmd.prod = PR_REFUSED;
								state_d  = S_FLUSH;
							end else begin
								cmd.start = 1'b1;
								if (stat.nmt_en) begin
									cmd.prod = PR_NMT;
									state_d  = S_FLUSH;
								end
							end
						end
						OP_STOP: cmd.stop = 1'b1;
						default: begin
							if (stat.playing) begin
								cmd.tick = 1'b1;
								if (!(stat.settling && stat.settle_gt1)) begin
									state_d = S_CHECK;
								end
							end
						end
					endcase
				end
			end
			S_CHECK: begin
				if (stat.idx_ge_cnt) begin
					if (!stat.loop_en || stat.table_empty) begin
						state_d = S_FINISH;
					end else begin
						cmd.rd_sel = RD_LAST;
						state_d    = S_LP;
					end
				end else begin
					state_d = S_FRAME;
				end
			end
			S_FRAME: begin
				if (stat.frame_late || stat.cap_hit) begin
					state_d = stat.pend_valid ? S_FLUSH : S_IDLE;
				end else if (can_prod) begin
					cmd.prod    = PR_FRAME;
					cmd.advance = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_LP: begin
				cmd.lp_set = 1'b1;
				cmd.rd_sel = RD_ZERO;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_lt) begin
					if (stat.scan_end) begin
						state_d = S_FINISH;
					end else begin
						cmd.scan_inc = 1'b1;
						cmd.rd_sel   = RD_SCAN_NEXT;
					end
				end else begin
					cmd.loop_hit = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_FINISH: begin
				if (can_prod) begin
					cmd.finish = 1'b1;
					cmd.prod   = PR_DONE;
					state_d    = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/tcfp_dp.sv @@
module tcfp_dp
	import tcfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [8:0]  frame_count_q;
	logic        loop_enable_q;
	logic [15:0] loop_from_q;
	logic        nmt_enable_q;
	logic [6:0]  node_id_q;
	logic [15:0] settle_ms_q;
	logic [5:0]  tx_cap_q;
	logic [15:0] window_ms_q;

	logic [15:0]      last_loaded_q;
	logic [CNT_W-1:0] play_idx_q;
	logic [15:0]      tape_q;
	logic [15:0]      settle_left_q;
	logic [15:0]      win_ticks_q;
	logic [5:0]       win_sent_q;
	logic             playing_q;
	logic             settling_q;
	logic [5:0]       tick_sent_q;
	logic [15:0]      lp_q;
	logic [CNT_W-1:0] scan_q;
	rsp_t             pend_q;
	logic             pend_valid_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic [CNT_W-1:0] cnt;
	logic [15:0]      ms_clamp;
	logic [15:0]      ms_load;
	logic [15:0]      win_inc;
	logic             ram_we;
	logic [IDX_W-1:0] rd_addr;
	logic [RAM_W-1:0] rd_data;
	logic [15:0]      rd_time;
	logic [10:0]      rd_id;
	logic [63:0]      rd_bytes;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] scan_p1;
	logic             out_free;
	rsp_t             new_rsp;

	assign cnt = (32'(frame_count_q) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(frame_count_q);
	assign cnt_m1  = cnt - CNT_W'(1);
	assign scan_p1 = scan_q + CNT_W'(1);

	assign ms_clamp = (req.offset_ms > OFFSET_MAX) ? OFFSET_MAX : req.offset_ms;
	assign ms_load  = (req.slot != 8'd0 && ms_clamp < last_loaded_q) ? last_loaded_q : ms_clamp;
	assign ram_we   = cmd.load && (32'(req.slot) < MAX_FRAMES);

	always_comb begin
		case (cmd.rd_sel)
			RD_LAST:      rd_addr = cnt_m1[IDX_W-1:0];
			RD_ZERO:      rd_addr = '0;
			RD_SCAN_NEXT: rd_addr = scan_p1[IDX_W-1:0];
			default:      rd_addr = play_idx_q[IDX_W-1:0];
		endcase
	end

	tcfp_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_FRAMES)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (req.slot[IDX_W-1:0]),
		.wr_data ({ms_load, req.frame_id, req.payload}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign {rd_time, rd_id, rd_bytes} = rd_data;

	assign win_inc  = win_ticks_q + 16'd1;
	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		new_rsp = '0;
		case (cmd.prod)
			PR_FRAME: begin
				new_rsp.kind     = KIND_FRAME;
				new_rsp.can_id   = rd_id;
				new_rsp.can_data = rd_bytes;
				new_rsp.can_len  = LEN_TAPE;
			end
			PR_NMT: begin
				new_rsp.kind     = KIND_FRAME;
				new_rsp.can_id   = NMT_ID;
				new_rsp.can_data = {48'd0, 1'b0, node_id_q, NMT_START};
				new_rsp.can_len  = LEN_NMT;
			end
			PR_REFUSED: new_rsp.kind = KIND_REFUSED;
			PR_DONE:    new_rsp.kind = KIND_DONE;
			default:    new_rsp = '0;
		endcase
	end

	assign stat.playing     = playing_q;
	assign stat.settling    = settling_q;
	assign stat.settle_gt1  = settle_left_q > 16'd1;
	assign stat.table_empty = (cnt == '0);
	assign stat.idx_ge_cnt  = play_idx_q >= cnt;
	assign stat.frame_late  = rd_time > tape_q;
	assign stat.cap_hit     = (win_sent_q >= tx_cap_q) || (tick_sent_q >= TICK_SEND_MAX);
	assign stat.scan_lt     = rd_time < lp_q;
	assign stat.scan_end    = scan_p1 >= cnt;
	assign stat.pend_valid  = pend_valid_q;
	assign stat.out_free    = out_free;
	assign stat.nmt_en      = nmt_enable_q;
	assign stat.loop_en     = loop_enable_q;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			loop_enable_q <= 1'b0;
			loop_from_q   <= '0;
			nmt_enable_q  <= 1'b1;
			node_id_q     <= NODE_ID_RST;
			settle_ms_q   <= SETTLE_RST;
			tx_cap_q      <= TX_CAP_RST;
			window_ms_q   <= WINDOW_RST;
			last_loaded_q <= '0;
			play_idx_q    <= '0;
			tape_q        <= '0;
			settle_left_q <= '0;
			win_ticks_q   <= '0;
			win_sent_q    <= '0;
			playing_q     <= 1'b0;
			settling_q    <= 1'b0;
			tick_sent_q   <= '0;
			lp_q          <= '0;
			scan_q        <= '0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FRAME_COUNT: frame_count_q <= cfg_data[8:0];
					CFG_LOOP_ENABLE: loop_enable_q <= cfg_data[0];
					CFG_LOOP_FROM:   loop_from_q   <= cfg_data;
					CFG_NMT_ENABLE:  nmt_enable_q  <= cfg_data[0];
					CFG_NODE_ID:     node_id_q     <= cfg_data[6:0];
					CFG_SETTLE_MS:   settle_ms_q   <= cfg_data;
					CFG_TX_CAP:      tx_cap_q      <= cfg_data[5:0];
					CFG_WINDOW_MS:   window_ms_q   <= cfg_data;
					default: ;
				endcase
			end

			if (ram_we) begin
				last_loaded_q <= ms_load;
			end

			if (cmd.start) begin
				playing_q     <= 1'b1;
				settling_q    <= 1'b1;
				settle_left_q <= settle_ms_q;
				play_idx_q    <= '0;
				tape_q        <= '0;
				win_ticks_q   <= '0;
				win_sent_q    <= '0;
			end

			if (cmd.stop) begin
				playing_q  <= 1'b0;
				settling_q <= 1'b0;
			end

			if (cmd.tick) begin
				tick_sent_q <= '0;
				if (win_inc >= window_ms_q) begin
					win_ticks_q <= '0;
					win_sent_q  <= '0;
				end else begin
					win_ticks_q <= win_inc;
				end
				if (settling_q) begin
					if (settle_left_q > 16'd1) begin
						settle_left_q <= settle_left_q - 16'd1;
					end else begin
						settle_left_q <= '0;
						settling_q    <= 1'b0;
						tape_q        <= '0;
					end
				end else if (tape_q != 16'hFFFF) begin
					tape_q <= tape_q + 16'd1;
				end
			end

			if (cmd.advance) begin
				play_idx_q  <= play_idx_q + CNT_W'(1);
				win_sent_q  <= win_sent_q + 6'd1;
				tick_sent_q <= tick_sent_q + 6'd1;
			end

			if (cmd.lp_set) begin
				lp_q   <= (loop_from_q > rd_time) ? 16'd0 : loop_from_q;
				scan_q <= '0;
			end

			if (cmd.scan_inc) begin
				scan_q <= scan_p1;
			end

			if (cmd.loop_hit) begin
				play_idx_q <= scan_q;
				tape_q     <= rd_time;
			end

			if (cmd.finish) begin
				playing_q <= 1'b0;
			end

			if (cmd.prod != PR_NONE) begin
				pend_q       <= new_rsp;
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_q       <= pend_q;
					out_valid_q <= 1'b1;
				end else if (!rsp_stall) begin
					out_valid_q <= 1'b0;
				end
			end else if (cmd.flush) begin
				out_q        <= {pend_q[$bits(rsp_t)-1:1], 1'b1};
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ tb/timed_can_frame_player_test.sv @@
`timescale 1ns / 100ps

module timed_can_frame_player_test;
	import tcfp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_PAUSE   = 600;
	localparam int LONG_HOLD      = 300;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	timed_can_frame_player dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// player shadow: table, control state and registers
	logic [15:0] m_time [MAX_FRAMES];
	logic [10:0] m_ident [MAX_FRAMES];
	logic [63:0] m_bytes [MAX_FRAMES];
	logic [15:0] m_last_loaded;
	int          m_idx;
	logic [15:0] m_tape;
	logic [15:0] m_settle_left;
	logic [15:0] m_wticks;
	logic [5:0]  m_wsent;
	bit          m_playing;
	bit          m_settling;

	logic [8:0]  c_count;
	bit          c_loop;
	logic [15:0] c_loop_from;
	bit          c_nmt;
	logic [6:0]  c_node;
	logic [15:0] c_settle;
	logic [5:0]  c_cap;
	logic [15:0] c_window;

	rsp_t awaited_rsp[$];
	int   errors;
	int   n_req;
	int   n_rsp;
	int   n_frames;
	int   n_done;
	int   n_refused;
	int   idle_cycles;
	int   hold_len;
	bit   quiet;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [15:0] val;
		req_t        r;
		bit          typed;
		rsp_t        exp;
	} row_t;

	row_t script[$];

	function automatic rsp_t mk_rsp(logic [1:0] kind, logic [10:0] id, logic [63:0] data,
			logic [3:0] len);
		rsp_t x;
		x.kind = kind;
		x.can_id = id;
		x.can_data = data;
		x.can_len = len;
		x.last = 1'b0;
		return x;
	endfunction

	function automatic req_t mk_req(logic [1:0] op, logic [7:0] slot, logic [15:0] off,
			logic [10:0] id, logic [63:0] pl);
		req_t x;
		x.op = op;
		x.slot = slot;
		x.offset_ms = off;
		x.frame_id = id;
		x.payload = pl;
		return x;
	endfunction

	task automatic reset_player();
		m_last_loaded = '0;
		m_idx = 0;
		m_tape = '0;
		m_settle_left = '0;
		m_wticks = '0;
		m_wsent = '0;
		m_playing = 0;
		m_settling = 0;
		c_count = '0;
		c_loop = 0;
		c_loop_from = '0;
		c_nmt = 1;
		c_node = NODE_ID_RST;
		c_settle = SETTLE_RST;
		c_cap = TX_CAP_RST;
		c_window = WINDOW_RST;
	endtask

	task automatic apply_reg(logic [2:0] idx, logic [15:0] v);
		case (idx)
			CFG_FRAME_COUNT: c_count = v[8:0];
			CFG_LOOP_ENABLE: c_loop = v[0];
			CFG_LOOP_FROM:   c_loop_from = v;
			CFG_NMT_ENABLE:  c_nmt = v[0];
			CFG_NODE_ID:     c_node = v[6:0];
			CFG_SETTLE_MS:   c_settle = v;
			CFG_TX_CAP:      c_cap = v[5:0];
			CFG_WINDOW_MS:   c_window = v;
			default: ;
		endcase
	endtask

	task automatic play_model(input req_t r, ref rsp_t outs[$]);
		int          cnt;
		int          i;
		logic [15:0] lp;
		logic [15:0] ms;
		cnt = (c_count > MAX_FRAMES) ? MAX_FRAMES : int'(c_count);
		case (r.op)
			OP_LOAD: begin
				ms = (r.offset_ms > OFFSET_MAX) ? OFFSET_MAX : r.offset_ms;
				if (r.slot != 0 && ms < m_last_loaded)
					ms = m_last_loaded;
				m_last_loaded = ms;
				m_time[r.slot] = ms;
				m_ident[r.slot] = r.frame_id;
				m_bytes[r.slot] = r.payload;
			end
			OP_START: begin
				if (cnt == 0) begin
					outs.push_back(mk_rsp(KIND_REFUSED, '0, '0, '0));
				end else begin
					m_playing = 1;
					m_settling = 1;
					m_settle_left = c_settle;
					m_idx = 0;
					m_tape = '0;
					m_wticks = '0;
					m_wsent = '0;
					if (c_nmt)
						outs.push_back(mk_rsp(KIND_FRAME, NMT_ID,
							{48'd0, 1'b0, c_node, NMT_START}, LEN_NMT));
				end
			end
			OP_STOP: begin
				m_playing = 0;
				m_settling = 0;
			end
			default: begin
				if (!m_playing)
					return;
				m_wticks = m_wticks + 16'd1;
				if (m_wticks >= c_window) begin
					m_wticks = '0;
					m_wsent = '0;
				end
				if (m_settling) begin
					if (m_settle_left > 1) begin
						m_settle_left = m_settle_left - 16'd1;
						return;
					end
					m_settle_left = '0;
					m_settling = 0;
					m_tape = '0;
				end else if (m_tape != 16'hFFFF) begin
					m_tape = m_tape + 16'd1;
				end
				forever begin
					if (m_idx >= cnt) begin
						if (!c_loop || cnt == 0) begin
							m_playing = 0;
							outs.push_back(mk_rsp(KIND_DONE, '0, '0, '0));
							break;
						end
						lp = c_loop_from;
						if (lp > m_time[cnt-1])
							lp = '0;
						i = 0;
						while (i < cnt && m_time[i] < lp)
							i++;
						if (i >= cnt) begin
							m_playing = 0;
							outs.push_back(mk_rsp(KIND_DONE, '0, '0, '0));
							break;
						end
						m_idx = i;
						m_tape = m_time[i];
					end
					if (m_time[m_idx] > m_tape)
						break;
					if (m_wsent >= c_cap || outs.size() >= TICK_SEND_MAX)
						break;
					outs.push_back(mk_rsp(KIND_FRAME, m_ident[m_idx], m_bytes[m_idx],
						LEN_TAPE));
					m_wsent = m_wsent + 6'd1;
					m_idx++;
				end
			end
		endcase
		if (outs.size() > 0)
			outs[outs.size()-1].last = 1'b1;
	endtask

	task automatic report(string what);
		errors++;
		$display("ERROR %0t: %s", $realtime, what);
	endtask

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// response checker and watchdog
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
			if (rsp_valid && !rsp_stall) begin
				n_rsp++;
				if (awaited_rsp.size() == 0) begin
					report($sformatf("unexpected result %h", rsp));
				end else begin
					e = awaited_rsp.pop_front();
					if (rsp.kind !== e.kind || rsp.can_id !== e.can_id ||
							rsp.can_data !== e.can_data || rsp.can_len !== e.can_len ||
							rsp.last !== e.last)
						report($sformatf("kind %0d/%0d id %h/%h data %h/%h len %0d/%0d last %b/%b",
							rsp.kind, e.kind, rsp.can_id, e.can_id, rsp.can_data,
							e.can_data, rsp.can_len, e.can_len, rsp.last, e.last));
					if (e.kind == KIND_FRAME)
						n_frames++;
					else if (e.kind == KIND_DONE)
						n_done++;
					else
						n_refused++;
				end
			end
		end
	end

	// receiver stall: random bursts unless quiet, a long hold on request
	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic send(input req_t r, input bit typed = 0, input rsp_t exp = '0);
		rsp_t outs[$];
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		n_req++;
		play_model(r, outs);
		if (typed) begin
			exp.last = 1'b1;
			awaited_rsp.push_back(exp);
		end else begin
			foreach (outs[k])
				awaited_rsp.push_back(outs[k]);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		wait (awaited_rsp.size() == 0);
		repeat (SETTLE_PAUSE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_reg(idx, v);
	endtask

	task automatic run_phase(int tbl_n, int fc, bit lpe, int lpf, bit nmt, int node,
			int settle, int cap, int window, int ops, bit hold);
		int          off;
		int          pick;
		logic [15:0] o;
		drain();
		off = $urandom_range(0, 3);
		for (int s = 0; s < tbl_n; s++) begin
			send(mk_req(OP_LOAD, s[7:0], off[15:0], 11'($urandom),
				{$urandom, $urandom}));
			off += $urandom_range(0, 3);
		end
		drain();
		write_reg(CFG_FRAME_COUNT, fc[15:0]);
		write_reg(CFG_LOOP_ENABLE, {15'd0, lpe});
		write_reg(CFG_LOOP_FROM, lpf[15:0]);
		write_reg(CFG_NMT_ENABLE, {15'd0, nmt});
		write_reg(CFG_NODE_ID, node[15:0]);
		write_reg(CFG_SETTLE_MS, settle[15:0]);
		write_reg(CFG_TX_CAP, cap[15:0]);
		write_reg(CFG_WINDOW_MS, window[15:0]);
		send(mk_req(OP_START, 8'($urandom), 16'($urandom), 11'($urandom),
			{$urandom, $urandom}));
		if (hold)
			hold_len = LONG_HOLD;
		for (int k = 0; k < ops; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				send(mk_req(OP_TICK, 8'($urandom), 16'($urandom), 11'($urandom),
					{$urandom, $urandom}));
			end else if (pick < 76) begin
				send(mk_req(OP_START, 8'($urandom), 16'($urandom), 11'($urandom),
					{$urandom, $urandom}));
			end else if (pick < 82) begin
				send(mk_req(OP_STOP, 8'($urandom), 16'($urandom), 11'($urandom),
					{$urandom, $urandom}));
			end else begin
				o = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
				send(mk_req(OP_LOAD, 8'($urandom_range(0, 255)), o, 11'($urandom),
					{$urandom, $urandom}));
			end
		end
		send(mk_req(OP_STOP, '0, '0, '0, '0));
	endtask

	task automatic add_req(req_t r, bit typed = 0, rsp_t exp = '0);
		row_t x;
		x = '{is_cfg: 0, idx: '0, val: '0, r: r, typed: typed, exp: exp};
		script.push_back(x);
	endtask

	task automatic add_cfg(logic [2:0] idx, logic [15:0] v);
		row_t x;
		x = '{is_cfg: 1, idx: idx, val: v, r: '0, typed: 0, exp: '0};
		script.push_back(x);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		n_req = 0;
		n_rsp = 0;
		n_frames = 0;
		n_done = 0;
		n_refused = 0;
		idle_cycles = 0;
		hold_len = 0;
		quiet = 0;
		reset_player();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_req(mk_req(OP_START, '0, '0, '0, '0), 1, mk_rsp(KIND_REFUSED, '0, '0, '0));
		add_req(mk_req(OP_TICK, '0, '0, '0, '0));
		add_req(mk_req(OP_STOP, '0, '0, '0, '0));
		add_req(mk_req(OP_LOAD, 8'd255, 16'hFFFF, 11'h7FF, '1));
		add_req(mk_req(OP_LOAD, 8'd0, 16'd0, 11'h000, 64'd0));
		add_req(mk_req(OP_LOAD, 8'd1, 16'd5, 11'h555, 64'hAAAA_AAAA_AAAA_AAAA));
		add_req(mk_req(OP_LOAD, 8'd2, 16'd3, 11'h2AA, 64'h5555_5555_5555_5555));
		add_req(mk_req(OP_LOAD, 8'd3, 16'd10, 11'h123, 64'h0123_4567_89AB_CDEF));
		add_cfg(CFG_FRAME_COUNT, 16'd4);
		add_cfg(CFG_SETTLE_MS, 16'd2);
		add_cfg(CFG_TX_CAP, 16'd1);
		add_cfg(CFG_WINDOW_MS, 16'd2);
		add_req(mk_req(OP_START, '0, '0, '0, '0), 1,
			mk_rsp(KIND_FRAME, NMT_ID, {48'd0, 1'b0, NODE_ID_RST, NMT_START}, LEN_NMT));
		repeat (8)
			add_req(mk_req(OP_TICK, '0, '0, '0, '0));
		add_cfg(CFG_LOOP_ENABLE, 16'd1);
		add_cfg(CFG_LOOP_FROM, 16'd7);
		add_cfg(CFG_NMT_ENABLE, 16'd0);
		add_cfg(CFG_NODE_ID, 16'd127);
		add_cfg(CFG_TX_CAP, 16'd63);
		add_req(mk_req(OP_START, '0, '0, '0, '0));
		repeat (7)
			add_req(mk_req(OP_TICK, '0, '0, '0, '0));
		add_req(mk_req(OP_STOP, '0, '0, '0, '0));

		foreach (script[k]) begin
			if (script[k].is_cfg) begin
				drain();
				write_reg(script[k].idx, script[k].val);
			end else begin
				send(script[k].r, script[k].typed, script[k].exp);
			end
		end

		run_phase(64, 64, 1, 65000, 1, 0, 1, 63, 1, 30, 1);
		run_phase(6, 0, 0, 0, 1, 5, 3, 24, 1000, 12, 0);
		run_phase(4, 4, 0, 0, 1, 127, 65535, 24, 1000, 6, 0);
		run_phase(8, 8, 1, $urandom_range(0, 65000), 0, $urandom_range(0, 127),
			1, 1, 65535, 25, 0);
		repeat (3)
			run_phase($urandom_range(2, 16), $urandom_range(1, 2), $urandom_range(0, 1),
				$urandom_range(0, 30), $urandom_range(0, 1), $urandom_range(0, 127),
				$urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 20), 20, 0);
		run_phase(12, 12, 1, $urandom_range(0, 30), 1, $urandom_range(0, 127),
			2, $urandom_range(1, 63), $urandom_range(1, 10), 20, 0);
		quiet = 1;
		run_phase(10, 10, 1, 4, 1, 33, 1, 3, 4, 20, 0);
		drain();

		$display("Run covered %0d requests and %0d results: %0d CAN frames, %0d finishes,",
			n_req, n_rsp, n_frames, n_done);
		$display("%0d refused starts, over directed rows and randomized playback phases",
			n_refused);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
